>>> hw/rtl/ltbs_pkg.sv
// ----------------------------------------------------------------------------
// ltbs_pkg
// Shared types and constants of the token boundary scanner: byte codes,
// token kinds, the classified item that crosses the front queue, the result.
// ----------------------------------------------------------------------------
`default_nettype none

package ltbs_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BANG   = 8'h21;

    localparam logic [2:0] KIND_SEP  = 3'd0;
    localparam logic [2:0] KIND_WORD = 3'd1;
    localparam logic [2:0] KIND_NUM  = 3'd2;
    localparam logic [2:0] KIND_STR  = 3'd3;
    localparam logic [2:0] KIND_SYM  = 3'd4;

    typedef struct packed {
        logic is_blank;
        logic is_digit;
        logic is_word;
        logic is_quote;
        logic is_sym_start;
        logic is_period;
        logic is_bslash;
        logic is_eq;
        logic is_plus;
        logic is_minus;
    } ltbs_class_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        ltbs_class_t cls;
    } ltbs_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic [2:0] token_kind;
        logic       starts_token;
        logic       closes_previous;
        logic       closes_here;
        logic       open_string_at_end;
        logic       last;
    } ltbs_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ltbs_classify.sv
// ----------------------------------------------------------------------------
// ltbs_classify
// Front part: sorts each incoming byte into the character classes the
// scanner needs and packs it into a queue item.
// ----------------------------------------------------------------------------
`default_nettype none

module ltbs_classify (
    input  wire logic [7:0]          char_in,
    input  wire logic                last_char,
    output ltbs_pkg::ltbs_item_t     item
);
    import ltbs_pkg::*;

    logic is_digit;

    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);

    always_comb
    begin
        item.ch               = char_in;
        item.last             = last_char;
        item.cls.is_blank     = (char_in == CH_SPACE) || (char_in == CH_NL) ||
                                (char_in == CH_TAB);
        item.cls.is_digit     = is_digit;
        item.cls.is_word      = is_digit ||
                                ((char_in >= CH_UPPER_A) && (char_in <= CH_LOWER_Z));
        item.cls.is_quote     = (char_in == CH_DQUOTE) || (char_in == CH_SQUOTE);
        item.cls.is_sym_start = (char_in == CH_PLUS)   || (char_in == CH_MINUS)  ||
                                (char_in == CH_SLASH)  || (char_in == CH_STAR)   ||
                                (char_in == CH_LPAREN) || (char_in == CH_RPAREN) ||
                                (char_in == CH_EQ)     || (char_in == CH_SEMI)   ||
                                (char_in == CH_LT)     || (char_in == CH_GT)     ||
                                (char_in == CH_HASH)   || (char_in == CH_BANG);
        item.cls.is_period    = (char_in == CH_PERIOD);
        item.cls.is_bslash    = (char_in == CH_BSLASH);
        item.cls.is_eq        = (char_in == CH_EQ);
        item.cls.is_plus      = (char_in == CH_PLUS);
        item.cls.is_minus     = (char_in == CH_MINUS);
    end

endmodule

`default_nettype wire

>>> hw/rtl/ltbs_fifo.sv
// ----------------------------------------------------------------------------
// ltbs_fifo
// Short queue between the classifier and the scanner so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ltbs_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  ltbs_pkg::ltbs_item_t      wr_item,
    output logic                      full,
    output logic                      rd_valid,
    input  wire logic                 rd_en,
    output ltbs_pkg::ltbs_item_t      rd_item
);
    import ltbs_pkg::*;

    ltbs_item_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ltbs_scan.sv
// ----------------------------------------------------------------------------
// ltbs_scan
// Back part: runs the token state machine on classified items and holds
// each result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ltbs_scan (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  ltbs_pkg::ltbs_item_t      in_item,
    output logic                      in_take,
    output logic                      out_valid,
    input  wire logic                 out_pop,
    output ltbs_pkg::ltbs_result_t    out_result
);
    import ltbs_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_STR  = 3'd3,
        MODE_ESC  = 3'd4,
        MODE_SYM  = 3'd5
    } mode_t;

    mode_t        mode_reg;
    mode_t        mode_next;
    logic         period_reg;
    logic         period_next;
    logic [7:0]   first_reg;
    logic [7:0]   first_next;
    logic         second_reg;
    logic         second_next;
    logic         out_valid_reg;
    ltbs_result_t result_reg;
    ltbs_result_t result_next;

    logic         taken;
    logic         sec_ok;
    ltbs_class_t  cls;

    assign cls        = in_item.cls;
    assign in_take    = in_valid && (!out_valid_reg || out_pop);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        if (cls.is_eq)
        begin
            sec_ok = (first_reg == CH_PLUS) || (first_reg == CH_MINUS) ||
                     (first_reg == CH_SLASH) || (first_reg == CH_STAR) ||
                     (first_reg == CH_EQ) || (first_reg == CH_BANG);
        end
        else if (cls.is_plus)
        begin
            sec_ok = (first_reg == CH_PLUS);
        end
        else if (cls.is_minus)
        begin
            sec_ok = (first_reg == CH_MINUS);
        end
        else
        begin
            sec_ok = 1'b0;
        end
    end

    always_comb
    begin
        taken       = 1'b0;
        mode_next   = mode_reg;
        period_next = period_reg;
        first_next  = first_reg;
        second_next = second_reg;

        result_next.char_out           = in_item.ch;
        result_next.token_kind         = KIND_SEP;
        result_next.starts_token       = 1'b0;
        result_next.closes_previous    = 1'b0;
        result_next.closes_here        = 1'b0;
        result_next.open_string_at_end = 1'b0;
        result_next.last               = in_item.last;

        unique case (mode_reg)
            MODE_WORD:
            begin
                if (cls.is_word)
                begin
                    taken                  = 1'b1;
                    result_next.token_kind = KIND_WORD;
                end
            end
            MODE_NUM:
            begin
                if (!period_reg && cls.is_period)
                begin
                    period_next = 1'b1;
                    taken       = 1'b1;
                end
                else if (cls.is_digit)
                begin
                    taken = 1'b1;
                end
                if (taken)
                begin
                    result_next.token_kind = KIND_NUM;
                end
            end
            MODE_STR:
            begin
                taken                  = 1'b1;
                result_next.token_kind = KIND_STR;
                if (cls.is_bslash)
                begin
                    mode_next = MODE_ESC;
                end
                else if (cls.is_quote)
                begin
                    result_next.closes_here = 1'b1;
                    mode_next               = MODE_IDLE;
                end
            end
            MODE_ESC:
            begin
                taken                  = 1'b1;
                result_next.token_kind = KIND_STR;
                mode_next              = MODE_STR;
            end
            MODE_SYM:
            begin
                if (!second_reg && sec_ok)
                begin
                    second_next            = 1'b1;
                    taken                  = 1'b1;
                    result_next.token_kind = KIND_SYM;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (!taken)
        begin
            result_next.closes_previous = (mode_next != MODE_IDLE);
            mode_next                   = MODE_IDLE;
            if (!cls.is_blank)
            begin
                result_next.starts_token = 1'b1;
                priority if (cls.is_digit)
                begin
                    mode_next              = MODE_NUM;
                    period_next            = 1'b0;
                    result_next.token_kind = KIND_NUM;
                end
                else if (cls.is_quote)
                begin
                    mode_next              = MODE_STR;
                    result_next.token_kind = KIND_STR;
                end
                else if (cls.is_sym_start)
                begin
                    mode_next              = MODE_SYM;
                    first_next             = in_item.ch;
                    second_next            = 1'b0;
                    result_next.token_kind = KIND_SYM;
                end
                else
                begin
                    mode_next              = MODE_WORD;
                    result_next.token_kind = KIND_WORD;
                end
            end
        end

        if (in_item.last)
        begin
            if (mode_next != MODE_IDLE)
            begin
                result_next.closes_here        = 1'b1;
                result_next.open_string_at_end = (mode_next == MODE_STR) ||
                                                 (mode_next == MODE_ESC);
            end
            mode_next   = MODE_IDLE;
            period_next = 1'b0;
            first_next  = '0;
            second_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            period_reg    <= 1'b0;
            first_reg     <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                mode_reg      <= mode_next;
                period_reg    <= period_next;
                first_reg     <= first_next;
                second_reg    <= second_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lexer_token_boundary_scanner.sv
// A pushed byte is queued first; the scanner then registers its result.
// Throughput: one byte per cycle, sustained while results are popped.
// The classifier writes a four-entry queue; the scanner state machine drains
// it into a one-entry output register that parts it from the pop side.
// Reset (rst_n low, asynchronous): queue empty, scan mode idle, no result.
// ----------------------------------------------------------------------------
// lexer_token_boundary_scanner
// Marks token boundaries and token kinds in a byte stream, one byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

module lexer_token_boundary_scanner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  char_in,
    input  wire logic        last_char,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       char_out,
    output logic [2:0]       token_kind,
    output logic             starts_token,
    output logic             closes_previous,
    output logic             closes_here,
    output logic             open_string_at_end,
    output logic             last
);
    import ltbs_pkg::*;

    ltbs_item_t   wr_item;
    ltbs_item_t   rd_item;
    ltbs_result_t result;
    logic         q_valid;
    logic         q_take;
    logic         out_valid;

    ltbs_classify u_classify (
        .char_in   (char_in),
        .last_char (last_char),
        .item      (wr_item)
    );

    ltbs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_item  (wr_item),
        .full     (full),
        .rd_valid (q_valid),
        .rd_en    (q_take),
        .rd_item  (rd_item)
    );

    ltbs_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_item    (rd_item),
        .in_take    (q_take),
        .out_valid  (out_valid),
        .out_pop    (pop),
        .out_result (result)
    );

    assign empty              = !out_valid;
    assign char_out           = result.char_out;
    assign token_kind         = result.token_kind;
    assign starts_token       = result.starts_token;
    assign closes_previous    = result.closes_previous;
    assign closes_here        = result.closes_here;
    assign open_string_at_end = result.open_string_at_end;
    assign last               = result.last;

endmodule

`default_nettype wire

>>> hw/rtl/ltbs_checker.sv
// ----------------------------------------------------------------------------
// ltbs_checker
// Port-level checks of the token boundary scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ltbs_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [7:0]  char_out,
    input  wire logic [2:0]  token_kind,
    input  wire logic        starts_token,
    input  wire logic        closes_here,
    input  wire logic        open_string_at_end,
    input  wire logic        last
);
    import ltbs_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(char_out) && $stable(token_kind) &&
                              $stable(last)))
        else $error("waiting item changed before pop");

    a_open_str: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && open_string_at_end) |->
            (last && closes_here && token_kind == KIND_STR))
        else $error("open string flag without a final string byte");

    a_start_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && starts_token) |-> (token_kind != KIND_SEP))
        else $error("token start on a separator");

    a_close_here: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && closes_here && !last) |-> (token_kind == KIND_STR))
        else $error("early close outside a string");

endmodule

bind lexer_token_boundary_scanner ltbs_checker u_ltbs_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .empty              (empty),
    .pop                (pop),
    .char_out           (char_out),
    .token_kind         (token_kind),
    .starts_token       (starts_token),
    .closes_here        (closes_here),
    .open_string_at_end (open_string_at_end),
    .last               (last)
);

`default_nettype wire
